// File: rtl/tfsk_pkg.sv
// Shared types and constants for the two-tone FSK word modulator.
// Used by tfsk_cfg, tfsk_core and the top level; depends on nothing else.
package tfsk_pkg;

    // Configuration port geometry: three 32-bit registers at byte offsets 0, 4 and 8.
    localparam int unsigned APB_ADDR_W = 4;
    localparam int unsigned APB_DATA_W = 32;
    localparam int unsigned TICK_W     = 32;

    // Register reset values, in ticks.
    localparam logic [TICK_W-1:0] TONE_ONE_RESET  = 32'd500;
    localparam logic [TICK_W-1:0] TONE_ZERO_RESET = 32'd1000;
    localparam logic [TICK_W-1:0] BIT_DUR_RESET   = 32'd10000;

    // Register index, taken from paddr[3:2].
    typedef enum logic [1:0] {
        REG_TONE_ONE  = 2'd0,
        REG_TONE_ZERO = 2'd1,
        REG_BIT_DUR   = 2'd2
    } reg_index_t;

    // Kind of an input transaction, carried in s_tuser.
    typedef enum logic {
        OP_TICK  = 1'b0,
        OP_START = 1'b1
    } opcode_t;

    // Timing registers as seen by the core.
    typedef struct packed {
        logic [TICK_W-1:0] tone_one_half_period;
        logic [TICK_W-1:0] tone_zero_half_period;
        logic [TICK_W-1:0] bit_duration;
    } cfg_t;

    // One result item, lowest field last in the packed order.
    typedef struct packed {
        logic rejected;
        logic word_done;
        logic busy_res;
        logic pin_level;
    } res_t;

endpackage

// File: rtl/tfsk_cfg.sv
// Configuration register file of the FSK modulator with its APB-style port.
// Depends on tfsk_pkg for the register map, widths and reset values.
module tfsk_cfg
    import tfsk_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    output cfg_t                  cfg
);

    logic [TICK_W-1:0] tone_one_reg;
    logic [TICK_W-1:0] tone_zero_reg;
    logic [TICK_W-1:0] bit_dur_reg;
    logic              wr_en;
    reg_index_t        index;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;
    assign index  = reg_index_t'(paddr[3:2]);

    // Register writes complete in the access phase of a transaction.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tone_one_reg  <= TONE_ONE_RESET;
            tone_zero_reg <= TONE_ZERO_RESET;
            bit_dur_reg   <= BIT_DUR_RESET;
        end
        else if (wr_en)
        begin
            case (index)
                REG_TONE_ONE:  tone_one_reg  <= pwdata;
                REG_TONE_ZERO: tone_zero_reg <= pwdata;
                REG_BIT_DUR:   bit_dur_reg   <= pwdata;
                default:       ;
            endcase
        end
    end

    // Read data; an unmapped address reads as zero.
    always_comb
    begin
        case (index)
            REG_TONE_ONE:  prdata = tone_one_reg;
            REG_TONE_ZERO: prdata = tone_zero_reg;
            REG_BIT_DUR:   prdata = bit_dur_reg;
            default:       prdata = '0;
        endcase
    end

    assign cfg.tone_one_half_period  = tone_one_reg;
    assign cfg.tone_zero_half_period = tone_zero_reg;
    assign cfg.bit_duration          = bit_dur_reg;

endmodule

// File: rtl/tfsk_core.sv
// Modulator state and its single-pass update for one accepted transaction.
// Depends on tfsk_pkg for cfg_t, res_t and the opcode codes.
module tfsk_core
    import tfsk_pkg::*;
#(
    parameter int unsigned WORD_BITS = 64
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 step,
    input  opcode_t              opcode,
    input  logic [WORD_BITS-1:0] word,
    input  cfg_t                 cfg,
    output res_t                 res
);

    localparam int unsigned CNT_W = $clog2(WORD_BITS + 1);

    logic [WORD_BITS-1:0] shift_word_reg, shift_word_next;
    logic [CNT_W-1:0]     bits_left_reg, bits_left_next;
    logic [TICK_W-1:0]    bit_cnt_reg, bit_cnt_next;
    logic [TICK_W-1:0]    half_cnt_reg, half_cnt_next;
    logic                 tone_reg, tone_next;
    logic                 level_reg, level_next;
    logic                 sending_reg, sending_next;

    logic [TICK_W-1:0]    half_sel;
    logic [TICK_W-1:0]    half_lim;
    logic [TICK_W-1:0]    dur_lim;
    logic [TICK_W-1:0]    half_inc;
    logic [TICK_W-1:0]    bit_inc;
    logic [WORD_BITS-1:0] shifted;
    logic [CNT_W-1:0]     bits_dec;
    logic                 toggle;
    logic                 bit_end;
    logic                 done;
    logic                 rej;

    // Limits for the current tone; a zero register value counts as one tick.
    assign half_sel = tone_reg ? cfg.tone_one_half_period : cfg.tone_zero_half_period;
    assign half_lim = (half_sel == '0) ? TICK_W'(1) : half_sel;
    assign dur_lim  = (cfg.bit_duration == '0) ? TICK_W'(1) : cfg.bit_duration;
    assign half_inc = half_cnt_reg + TICK_W'(1);
    assign bit_inc  = bit_cnt_reg + TICK_W'(1);
    assign toggle   = (half_inc >= half_lim);
    assign bit_end  = (bit_inc >= dur_lim);
    assign shifted  = shift_word_reg << 1;
    assign bits_dec = bits_left_reg - CNT_W'(1);

    // Next state for a start request or a tick.
    always_comb
    begin
        shift_word_next = shift_word_reg;
        bits_left_next  = bits_left_reg;
        bit_cnt_next    = bit_cnt_reg;
        half_cnt_next   = half_cnt_reg;
        tone_next       = tone_reg;
        level_next      = level_reg;
        sending_next    = sending_reg;
        done            = 1'b0;
        rej             = 1'b0;

        if (opcode == OP_START)
        begin
            if (sending_reg)
            begin
                rej = 1'b1;
            end
            else
            begin
                // Latch the word and restart both counts on its first tone.
                shift_word_next = word;
                bits_left_next  = CNT_W'(WORD_BITS);
                bit_cnt_next    = '0;
                half_cnt_next   = '0;
                tone_next       = word[WORD_BITS-1];
                sending_next    = 1'b1;
            end
        end
        else if (sending_reg)
        begin
            // Half-period count and pin toggle come first.
            half_cnt_next = toggle ? '0 : half_inc;
            level_next    = level_reg ^ toggle;
            bit_cnt_next  = bit_end ? '0 : bit_inc;

            // Then the bit boundary: shift, and either finish or re-pick the tone.
            if (bit_end)
            begin
                shift_word_next = shifted;
                bits_left_next  = bits_dec;
                if (bits_dec == '0)
                begin
                    level_next    = 1'b0;
                    sending_next  = 1'b0;
                    half_cnt_next = '0;
                    done          = 1'b1;
                end
                else if (shifted[WORD_BITS-1] != tone_reg)
                begin
                    tone_next     = shifted[WORD_BITS-1];
                    half_cnt_next = '0;
                end
            end
        end
    end

    // Control state, the word and the counters are all cleared by reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shift_word_reg <= '0;
            bits_left_reg  <= '0;
            bit_cnt_reg    <= '0;
            half_cnt_reg   <= '0;
            tone_reg       <= 1'b0;
            level_reg      <= 1'b0;
            sending_reg    <= 1'b0;
        end
        else if (step)
        begin
            shift_word_reg <= shift_word_next;
            bits_left_reg  <= bits_left_next;
            bit_cnt_reg    <= bit_cnt_next;
            half_cnt_reg   <= half_cnt_next;
            tone_reg       <= tone_next;
            level_reg      <= level_next;
            sending_reg    <= sending_next;
        end
    end

    // Result of this transaction, as the state stands after it.
    assign res.pin_level = level_next;
    assign res.busy_res  = sending_next;
    assign res.word_done = done;
    assign res.rejected  = rej;

    // The pin rests low whenever no word is in flight.
    a_idle_pin_low: assert property (@(posedge clk) disable iff (!rst_n)
        !sending_reg |-> !level_reg)
        else $error("pin high while idle");

    // The bit count is nonzero exactly while sending.
    a_bits_left: assert property (@(posedge clk) disable iff (!rst_n)
        sending_reg == (bits_left_reg != '0))
        else $error("bit count out of step with sending flag");

    // A rejected start leaves the word in flight untouched.
    a_reject_keeps: assert property (@(posedge clk) disable iff (!rst_n)
        step && opcode == OP_START && sending_reg
        |=> sending_reg && $stable(shift_word_reg) && $stable(bits_left_reg))
        else $error("rejected start disturbed the word in flight");

    // Finishing a word returns the block to idle.
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        step && done |=> !sending_reg && !level_reg)
        else $error("block still busy after last bit");

endmodule

// File: rtl/two_tone_fsk_word_modulator.sv
// Two-tone FSK word modulator: top level with stream ports and result register.
// Depends on tfsk_pkg, tfsk_cfg and tfsk_core.
//
// Usage: each input transaction on the s_ group is either a tick (s_tuser = 0) or a
// request to start sending the word in s_tdata (s_tuser = 1). Each accepted
// transaction yields exactly one result transaction on the m_ group with the pin
// level, the busy flag, the word-done flag and the rejected flag after that item.
// A start while a word is in flight is rejected and changes nothing.
// The result is registered and presented in the cycle after the input is accepted.
// Throughput: one item per cycle unless stalled; the state update is one 32-bit
// increment and compare per counter between the input handshake and the result
// register. Stall: s_tready stays high while the result register is empty or being
// taken; when the receiver holds m_tready low, the result is kept and input
// stops after one item.
// Reset: rst_n clears the state to idle with the pin low, empties the result
// register and loads the register reset values (500, 1000, 10000 ticks).
// The timing registers are written through the APB-style port at 0x0, 0x4, 0x8.
module two_tone_fsk_word_modulator
    import tfsk_pkg::*;
#(
    parameter int unsigned WORD_BITS = 64
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    // Input stream.
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [63:0]           s_tdata,   // [63:0] word
    input  logic [0:0]            s_tuser,   // [0] opcode
    // Result stream.
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [7:0]            m_tdata,   // [0] pin_level, [1] busy_res,
                                             // [2] word_done, [3] rejected, [7:4] zero
    // Configuration port.
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    cfg_t cfg;
    res_t res;
    res_t res_reg;
    logic out_valid_reg;
    logic step;

    tfsk_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Accept when the result register is free or drains in this cycle.
    assign s_tready = !out_valid_reg || m_tready;
    assign step     = s_tvalid && s_tready;

    tfsk_core #(
        .WORD_BITS (WORD_BITS)
    ) u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (step),
        .opcode (opcode_t'(s_tuser[0])),
        .word   (s_tdata[WORD_BITS-1:0]),
        .cfg    (cfg),
        .res    (res)
    );

    // Result register and its valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (step)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            res_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'b0000, res_reg};

endmodule

// File: bench/testbench.sv
// Self-checking bench for the two-tone FSK word modulator: drives tick and start
// commands on the input stream, programs the timing registers over the APB port,
// and checks every pin report. Depends on tfsk_pkg and two_tone_fsk_word_modulator.
module testbench;
    import tfsk_pkg::*;

    localparam int WORD_LEN      = 64;
    localparam int RANDOM_TARGET = 780;
    localparam int CALM_AT       = 680;
    localparam int HOLD_AT       = 350;
    localparam int LONG_HOLD     = 300;
    localparam int MAX_CYCLES    = 200000;

    // One input command: a tick or a request to send a word.
    typedef struct packed {
        opcode_t     op;
        logic [63:0] word;
    } fsk_command_t;

    logic clk;
    logic rst_n = 1'b0;

    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [63:0]           s_tdata  = '0;   // [63:0] word
    logic [0:0]            s_tuser  = '0;   // [0] opcode
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [7:0]            m_tdata;         // [0] pin_level, [1] busy_res,
                                            // [2] word_done, [3] rejected, [7:4] zero
    logic                  psel     = 1'b0;
    logic                  penable  = 1'b0;
    logic                  pwrite   = 1'b0;
    logic [APB_ADDR_W-1:0] paddr    = '0;
    logic [APB_DATA_W-1:0] pwdata   = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    fsk_command_t pending_commands[$];
    res_t         predicted_pin_reports[$];

    // Predictor state and its copy of the timing registers.
    logic [31:0]  half_one_ticks  = TONE_ONE_RESET;
    logic [31:0]  half_zero_ticks = TONE_ZERO_RESET;
    logic [31:0]  ticks_per_bit   = BIT_DUR_RESET;
    logic [63:0]  tx_word         = '0;
    logic [6:0]   bits_remaining  = '0;
    logic [31:0]  bit_ticks       = '0;
    logic [31:0]  half_ticks      = '0;
    logic         tone            = 1'b0;
    logic         level           = 1'b0;
    logic         active          = 1'b0;

    // Bench bookkeeping.
    logic took_input = 1'b0;
    logic calm       = 1'b0;
    int   failures;
    int   command_total;
    int   inputs_taken;
    int   reports_checked;
    int   words_started;
    int   words_finished;
    int   starts_rejected;
    int   settings_used;
    int   input_stall_cycles;
    int   cycle_count;
    int   gap_left;
    int   stall_left;
    int   hold_left;
    int   hold_state;

    two_tone_fsk_word_modulator #(
        .WORD_BITS(WORD_LEN)
    ) u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Counts and reports a failure; only the first ten are printed.
    task automatic note_failure(input string msg);
        failures++;
        if (failures <= 10)
            $display("MISMATCH: %s", msg);
    endtask

    // Advances the predicted modulator by one command and returns its pin report.
    function automatic res_t next_pin_report(input opcode_t op, input logic [63:0] w);
        res_t        r;
        logic [31:0] half;
        logic [31:0] dur;
        r = '0;
        if (op == OP_START)
        begin
            if (active)
            begin
                r.rejected = 1'b1;
            end
            else
            begin
                tx_word        = w;
                bits_remaining = 7'(WORD_LEN);
                bit_ticks      = '0;
                active         = 1'b1;
                tone           = w[WORD_LEN-1];
                half_ticks     = '0;
                words_started++;
            end
        end
        else if (active)
        begin
            half = tone ? half_one_ticks : half_zero_ticks;
            dur  = ticks_per_bit;
            if (half == 0)
                half = 1;
            if (dur == 0)
                dur = 1;
            // The toggle is applied before the bit boundary on the same tick.
            half_ticks = half_ticks + 32'd1;
            if (half_ticks >= half)
            begin
                level      = ~level;
                half_ticks = '0;
            end
            bit_ticks = bit_ticks + 32'd1;
            if (bit_ticks >= dur)
            begin
                bit_ticks      = '0;
                tx_word        = tx_word << 1;
                bits_remaining = bits_remaining - 7'd1;
                if (bits_remaining == 0)
                begin
                    level      = 1'b0;
                    active     = 1'b0;
                    half_ticks = '0;
                    r.word_done = 1'b1;
                end
                else if (tx_word[WORD_LEN-1] != tone)
                begin
                    // A new tone restarts its half period; the pin level is kept.
                    tone       = tx_word[WORD_LEN-1];
                    half_ticks = '0;
                end
            end
        end
        r.pin_level = level;
        r.busy_res  = active;
        return r;
    endfunction

    // Input driver: offers queued commands, with random idle bursts.
    always @(negedge clk)
    begin : drive_commands
        fsk_command_t cmd;
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
        end
        else if (!s_tvalid || took_input)
        begin
            if (gap_left > 0)
            begin
                gap_left--;
                s_tvalid <= 1'b0;
            end
            else if (pending_commands.size() > 0)
            begin
                cmd = pending_commands.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= cmd.word;
                s_tuser  <= cmd.op;
                if (!calm && $urandom_range(0, 7) == 0)
                    gap_left = $urandom_range(1, 6);
            end
            else
            begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Result receiver: random stall bursts plus one long hold while input is offered.
    always @(negedge clk)
    begin : drive_result_ready
        if (!rst_n)
        begin
            m_tready <= 1'b0;
        end
        else
        begin
            if (hold_state == 0 && inputs_taken >= HOLD_AT && s_tvalid)
            begin
                hold_state = 1;
                hold_left  = LONG_HOLD;
            end
            if (hold_state == 1)
            begin
                m_tready <= 1'b0;
                hold_left--;
                if (hold_left == 0)
                    hold_state = 2;
            end
            else if (stall_left > 0)
            begin
                m_tready <= 1'b0;
                stall_left--;
            end
            else
            begin
                m_tready <= 1'b1;
                if (!calm && $urandom_range(0, 7) == 0)
                    stall_left = $urandom_range(1, 6);
            end
        end
    end

    // Monitor: checks each result transaction, predicts each input transaction
    // and tracks register writes.
    always @(posedge clk)
    begin : observe
        res_t got;
        res_t want;
        if (!rst_n)
        begin
            took_input = 1'b0;
        end
        else
        begin
            took_input = s_tvalid && s_tready;
            if (m_tvalid && m_tready)
            begin
                got = res_t'(m_tdata[3:0]);
                if (predicted_pin_reports.size() == 0)
                begin
                    note_failure($sformatf("unexpected result tdata=%02h", m_tdata));
                end
                else
                begin
                    want = predicted_pin_reports.pop_front();
                    reports_checked++;
                    if (got.pin_level != want.pin_level || got.busy_res != want.busy_res ||
                        got.word_done != want.word_done || got.rejected != want.rejected ||
                        m_tdata[7:4] != 4'd0)
                        note_failure($sformatf(
                            {"result %0d: expected pin=%0b busy=%0b done=%0b rej=%0b pad=0, ",
                             "got pin=%0b busy=%0b done=%0b rej=%0b pad=%0h"},
                            reports_checked, want.pin_level, want.busy_res, want.word_done,
                            want.rejected, got.pin_level, got.busy_res, got.word_done,
                            got.rejected, m_tdata[7:4]));
                end
                if (got.word_done)
                    words_finished++;
                if (got.rejected)
                    starts_rejected++;
            end
            if (took_input)
            begin
                inputs_taken++;
                predicted_pin_reports.push_back(
                    next_pin_report(opcode_t'(s_tuser[0]), s_tdata));
            end
            if (s_tvalid && !s_tready)
                input_stall_cycles++;
            if (psel && penable && pwrite && pready)
            begin
                case (reg_index_t'(paddr[3:2]))
                    REG_TONE_ONE:  half_one_ticks  = pwdata;
                    REG_TONE_ZERO: half_zero_ticks = pwdata;
                    REG_BIT_DUR:   ticks_per_bit   = pwdata;
                    default: ;
                endcase
            end
        end
    end

    // Watchdog: ends a run that never drains.
    initial
    begin : watchdog
        cycle_count = 0;
        while (cycle_count < MAX_CYCLES)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("FAILURE");
        $finish;
    end

    // One APB transaction: setup cycle, then access cycle.
    task automatic apb_access(input logic wr, input reg_index_t idx,
                              input logic [31:0] wdata, output logic [31:0] rdata);
        @(negedge clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = wr;
        paddr   = {idx, 2'b00};
        pwdata  = wdata;
        @(negedge clk);
        penable = 1'b1;
        @(posedge clk);
        rdata = prdata;
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    // Writes all three timing registers and reads them back.
    task automatic program_timing(input logic [31:0] one, input logic [31:0] zero,
                                  input logic [31:0] dur);
        logic [31:0] vals [0:2];
        logic [31:0] rd;
        vals[0] = one;
        vals[1] = zero;
        vals[2] = dur;
        for (int i = 0; i < 3; i++)
            apb_access(1'b1, reg_index_t'(i), vals[i], rd);
        for (int i = 0; i < 3; i++)
        begin
            apb_access(1'b0, reg_index_t'(i), '0, rd);
            if (rd !== vals[i])
                note_failure($sformatf("register %0d read back %08h, expected %08h",
                                       i, rd, vals[i]));
        end
        settings_used++;
    endtask

    task automatic queue_command(input opcode_t op, input logic [63:0] w);
        fsk_command_t cmd;
        cmd.op   = op;
        cmd.word = w;
        pending_commands.push_back(cmd);
        command_total++;
    endtask

    // Waits until every command is taken and every report has arrived.
    task automatic wait_for_idle();
        while (pending_commands.size() != 0 || s_tvalid || predicted_pin_reports.size() != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    function automatic logic [63:0] random_word();
        case ($urandom_range(0, 5))
            0:       return {64{1'b1}};
            1:       return '0;
            2:       return {32{2'b10}};
            default: return {$urandom, $urandom};
        endcase
    endfunction

    function automatic logic [31:0] pick_half_period();
        case ($urandom_range(0, 9))
            0:       return 32'd0;
            1:       return 32'hFFFF_FFFF;
            default: return $urandom_range(1, 6);
        endcase
    endfunction

    // Queues whole words with random content, sprinkled with rejected starts.
    task automatic queue_words(input int n_words, input int ticks_each_bit);
        for (int n = 0; n < n_words; n++)
        begin
            repeat ($urandom_range(0, 2)) queue_command(OP_TICK, {$urandom, $urandom});
            queue_command(OP_START, random_word());
            for (int t = 0; t < WORD_LEN * ticks_each_bit; t++)
            begin
                queue_command(OP_TICK, {$urandom, $urandom});
                if ($urandom_range(0, 24) == 0)
                    queue_command(OP_START, {$urandom, $urandom});
            end
        end
        repeat ($urandom_range(1, 2)) queue_command(OP_TICK, {$urandom, $urandom});
    endtask

    initial
    begin : main_sequence
        logic [31:0] one;
        logic [31:0] zero;
        logic [31:0] dur;
        int          eff_dur;
        failures = 0;
        command_total = 0;
        inputs_taken = 0;
        reports_checked = 0;
        words_started = 0;
        words_finished = 0;
        starts_rejected = 0;
        settings_used = 0;
        input_stall_cycles = 0;
        gap_left = 0;
        stall_left = 0;
        hold_left = 0;
        hold_state = 0;

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Ticks while idle under the reset timing leave the pin low.
        queue_command(OP_TICK, {64{1'b1}});
        queue_command(OP_TICK, '0);
        wait_for_idle();

        // Fastest timing: a toggle and a bit end fall on every tick; a start while
        // busy is rejected; the last bit forces the pin low.
        program_timing(32'd1, 32'd2, 32'd1);
        queue_command(OP_START, {64{1'b1}});
        queue_command(OP_START, '0);
        repeat (WORD_LEN) queue_command(OP_TICK, '0);
        queue_command(OP_TICK, {64{1'b1}});
        wait_for_idle();

        // Zero register values act as one tick.
        program_timing(32'd0, 32'd0, 32'd0);
        queue_command(OP_START, '0);
        repeat (WORD_LEN) queue_command(OP_TICK, {64{1'b1}});
        queue_command(OP_TICK, '0);
        wait_for_idle();

        // Random settings, each phase made of complete words.
        while (command_total < RANDOM_TARGET)
        begin
            if (command_total >= CALM_AT)
                calm = 1'b1;
            one  = pick_half_period();
            zero = pick_half_period();
            dur  = ($urandom_range(0, 7) == 0) ? 32'd0 : $urandom_range(1, 2);
            eff_dur = (dur == 0) ? 1 : dur;
            program_timing(one, zero, dur);
            queue_words($urandom_range(1, 2), eff_dur);
            wait_for_idle();
        end

        // Largest values: the pin never toggles and the word stays in flight.
        calm = 1'b1;
        program_timing(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        queue_command(OP_START, random_word());
        repeat (30) queue_command(OP_TICK, {$urandom, $urandom});
        queue_command(OP_START, {$urandom, $urandom});
        repeat (10) queue_command(OP_TICK, {$urandom, $urandom});
        wait_for_idle();

        if (predicted_pin_reports.size() != 0)
            note_failure($sformatf("%0d reports never arrived", predicted_pin_reports.size()));

        $display("Checked %0d reports over %0d timing settings: %0d words started,",
                 reports_checked, settings_used, words_started);
        $display("%0d finished, %0d starts rejected; input held back %0d cycles; %0d mismatches.",
                 words_finished, starts_rejected, input_stall_cycles, failures);
        if (failures == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
